// ===== rtl/core/efb_pkg.sv =====
// Shared types, constants and the CRC-8 function of the escaped frame builder.
`timescale 1ns / 1ps

package efb_pkg;

    // Line control bytes.
    localparam logic [7:0] SOF_BYTE = 8'hC3;
    localparam logic [7:0] EOF_BYTE = 8'hC1;
    localparam logic [7:0] ESC_BYTE = 8'hC0;

    // CRC-8 polynomial, MSB first, init zero.
    localparam logic [7:0] CRC_POLY = 8'h2F;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One input request.
    typedef struct packed {
        logic       first_item;
        logic [1:0] packet_type;
        logic [2:0] target_station;
        logic       has_payload;
        logic [7:0] payload_byte;
        logic       last_item;
    } t_in_req;

    // One output request.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_last;
    } t_out_req;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic       first;
        logic [7:0] hdr;
        logic       pay_en;
        logic       esc;
        logic [7:0] pay;
        logic       last;
    } t_efb_cmd;

    // Byte steps of the back sequencer.
    typedef enum logic [2:0] {
        ST_START,
        ST_SOF,
        ST_HDR,
        ST_ESC,
        ST_PAY,
        ST_CRC,
        ST_EOF
    } t_efb_step;

    // Folds one byte into the CRC, one bit per step.
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/escaped_frame_builder_crc8.sv =====
// Top level of the escaped frame builder with CRC-8: front, command queue and back.
//
//   channel  direction  handshake          payload
//   in       input      valid / stall      t_in_req (one request per item)
//   out      output     valid / stall      t_out_req (one line byte per request)
//   cfg      input      valid / ready      own station id, 3 bits
//
// The back sends one line byte per cycle while the output is not stalled; an
// item makes one byte for a plain payload byte, two for an escaped one, and
// up to six for an item that opens and closes a packet.
// Items that make no byte are taken and dropped in the front and never enter the queue.
// The command queue holds QUEUE_DEPTH items, so the input stalls only when it is full.
// Reset is synchronous and active low; it clears the CRC, the station id and the queue.
`timescale 1ns / 1ps

module escaped_frame_builder_crc8 #(
    parameter int QUEUE_DEPTH = efb_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  efb_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output efb_pkg::t_out_req o_out_req,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_data
);

    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_q_valid;
    efb_pkg::t_efb_cmd w_cmd;
    efb_pkg::t_efb_cmd w_head;

    // Request intake and classification.
    efb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    // Command queue.
    efb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // Byte sequencer and CRC.
    efb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_head),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

// ===== rtl/core/efb_front.sv =====
// Front part: holds the station id, accepts requests and classifies them into commands.
`timescale 1ns / 1ps

module efb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  efb_pkg::t_in_req  i_in_req,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_data,
    input  logic              i_q_full,
    output logic              o_push,
    output efb_pkg::t_efb_cmd o_cmd
);

    logic [2:0] r_own_id;
    logic       w_special;
    logic       w_work;

    // Station id register, writable at any time.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= 3'd0;
        end else if (i_cfg_valid) begin
            r_own_id <= i_cfg_data;
        end
    end

    // A payload byte that collides with a control byte must be escaped.
    assign w_special = (i_in_req.payload_byte == efb_pkg::ESC_BYTE) ||
                       (i_in_req.payload_byte == efb_pkg::SOF_BYTE) ||
                       (i_in_req.payload_byte == efb_pkg::EOF_BYTE);

    // Requests that cause no output byte are taken and dropped here.
    assign w_work = i_in_req.first_item | i_in_req.has_payload | i_in_req.last_item;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full && w_work;

    // Build the command: header byte, escape flag and the byte that follows any escape.
    always_comb begin
        o_cmd.first  = i_in_req.first_item;
        o_cmd.hdr    = {i_in_req.target_station, r_own_id, i_in_req.packet_type};
        o_cmd.pay_en = i_in_req.has_payload;
        o_cmd.esc    = i_in_req.has_payload && w_special;
        o_cmd.pay    = w_special ? {2'b00, i_in_req.payload_byte[5:0]}
                                 : i_in_req.payload_byte;
        o_cmd.last   = i_in_req.last_item;
    end

endmodule

// ===== rtl/core/efb_queue.sv =====
// Short command queue that decouples the front from the back.
`timescale 1ns / 1ps

module efb_queue #(
    parameter int DEPTH = efb_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  efb_pkg::t_efb_cmd i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output efb_pkg::t_efb_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    efb_pkg::t_efb_cmd r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Pointer and fill-count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/efb_back.sv =====
// Back part: walks each command byte by byte, keeps the CRC and drives the output register.
`timescale 1ns / 1ps

module efb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  efb_pkg::t_efb_cmd i_q_head,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output efb_pkg::t_out_req o_out_req
);

    efb_pkg::t_efb_step r_step;
    efb_pkg::t_efb_step n_step;
    efb_pkg::t_efb_step w_eff;
    efb_pkg::t_efb_step w_next;
    efb_pkg::t_efb_step w_pay_step;
    logic [7:0]         r_crc;
    logic [7:0]         n_crc;
    logic [7:0]         w_crc_new;
    logic [7:0]         w_byte;
    logic               w_done;
    logic               w_adv;
    logic               w_fire;
    logic               r_out_valid;
    efb_pkg::t_out_req  r_out_req;

    // The output register moves whenever it is empty or being taken.
    assign w_adv  = !r_out_valid || !i_out_stall;
    assign w_fire = w_adv && i_q_valid;

    // Step sequencer: current byte, CRC update and following step.
    always_comb begin
        w_pay_step = i_q_head.esc ? efb_pkg::ST_ESC : efb_pkg::ST_PAY;
        if (r_step == efb_pkg::ST_START) begin
            if (i_q_head.first) begin
                w_eff = efb_pkg::ST_SOF;
            end else if (i_q_head.pay_en) begin
                w_eff = w_pay_step;
            end else begin
                w_eff = efb_pkg::ST_CRC;
            end
        end else begin
            w_eff = r_step;
        end

        w_byte    = efb_pkg::EOF_BYTE;
        w_crc_new = r_crc;
        w_done    = 1'b1;
        w_next    = efb_pkg::ST_START;
        case (w_eff)
            efb_pkg::ST_SOF: begin
                w_byte = efb_pkg::SOF_BYTE;
                w_done = 1'b0;
                w_next = efb_pkg::ST_HDR;
            end
            efb_pkg::ST_HDR: begin
                w_byte    = i_q_head.hdr;
                w_crc_new = efb_pkg::crc_fold(8'h00, i_q_head.hdr);
                if (i_q_head.pay_en) begin
                    w_done = 1'b0;
                    w_next = w_pay_step;
                end else if (i_q_head.last) begin
                    w_done = 1'b0;
                    w_next = efb_pkg::ST_CRC;
                end
            end
            efb_pkg::ST_ESC: begin
                w_byte    = efb_pkg::ESC_BYTE;
                w_crc_new = efb_pkg::crc_fold(r_crc, efb_pkg::ESC_BYTE);
                w_done    = 1'b0;
                w_next    = efb_pkg::ST_PAY;
            end
            efb_pkg::ST_PAY: begin
                w_byte    = i_q_head.pay;
                w_crc_new = efb_pkg::crc_fold(r_crc, i_q_head.pay);
                if (i_q_head.last) begin
                    w_done = 1'b0;
                    w_next = efb_pkg::ST_CRC;
                end
            end
            efb_pkg::ST_CRC: begin
                w_byte = r_crc;
                w_done = 1'b0;
                w_next = efb_pkg::ST_EOF;
            end
            efb_pkg::ST_EOF: begin
                w_byte = efb_pkg::EOF_BYTE;
            end
            default: begin
                w_byte = efb_pkg::EOF_BYTE;
            end
        endcase

        n_step = r_step;
        n_crc  = r_crc;
        if (w_fire) begin
            n_step = w_done ? efb_pkg::ST_START : w_next;
            n_crc  = w_crc_new;
        end
    end

    assign o_q_pop = w_fire && w_done;

    // State, CRC and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= efb_pkg::ST_START;
            r_crc       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_crc  <= n_crc;
            if (w_adv) begin
                r_out_valid <= i_q_valid;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_req.line_byte <= w_byte;
            r_out_req.run_last  <= w_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

`ifndef SYNTHESIS
    // The trailer is only ever started for a command that ends the packet.
    a_crc_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && w_eff == efb_pkg::ST_CRC) |-> i_q_head.last)
        else $error("CRC byte started for a command without last set");

    // A sequence in progress always has a command waiting in the queue.
    a_mid_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != efb_pkg::ST_START) |-> i_q_valid)
        else $error("sequencer mid-command with an empty queue");

    // Sending a header restarts the CRC from that header alone.
    a_hdr_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_eff == efb_pkg::ST_HDR) |=>
            (r_crc == $past(efb_pkg::crc_fold(8'h00, i_q_head.hdr))))
        else $error("CRC not restarted from the header");

    // The escape byte is always followed by the payload step of the same command.
    a_esc_then_pay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_eff == efb_pkg::ST_ESC) |=> (r_step == efb_pkg::ST_PAY))
        else $error("escape byte not followed by its payload byte");
`endif

endmodule
